[hdl/tphc_pkg.sv]
// tphc_pkg: shared types, codes and constants of the sensor compensation pipeline.
// Holds the restoring-divider step used by tphc_div. No dependencies.
package tphc_pkg;

  // Disabled-measurement codes
  localparam logic [23:0] DIS24 = 24'h800000;
  localparam logic [15:0] DIS16 = 16'h8000;

  // Arithmetic constants
  localparam logic signed [32:0] PRESS_TF_OFS = 33'sd128000;
  localparam logic signed [31:0] HUM_TF_OFS   = 32'sd76800;
  localparam logic signed [12:0] PRESS_SCALE  = 13'sd3125;
  localparam logic [20:0]        PRESS_BASE   = 21'd1048576;
  localparam logic signed [63:0] PRESS_V1_OFS = 64'sh0000_8000_0000_0000;
  localparam logic signed [31:0] HUM_MAX      = 32'sd419430400;
  localparam logic [16:0]        HUM_MAX_OUT  = 17'd102400;
  localparam logic signed [31:0] RND_128      = 32'sd128;
  localparam logic signed [31:0] RND_16384    = 32'sd16384;
  localparam logic signed [31:0] RND_8192     = 32'sd8192;
  localparam logic signed [31:0] OFS_32768    = 32'sd32768;
  localparam logic signed [31:0] OFS_2097152  = 32'sd2097152;

  localparam int DivSteps = 64;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_TEMP    = 3'd0,
    CFG_PLO     = 3'd1,
    CFG_PHI     = 3'd2,
    CFG_P9      = 3'd3,
    CFG_HUM     = 3'd4,
    CFG_HAS_HUM = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic temp_ok;
    logic press_ok;
    logic hum_ok;
  } flags_t;

  // Results that ride alongside the pressure divider
  typedef struct packed {
    logic signed [31:0] temp_centi;
    logic               temp_ok;
    logic               press_ok;
    logic               press_zero;
    logic               neg;
    logic [16:0]        hum;
    logic               hum_ok;
  } side_t;

  typedef struct packed {
    logic [30:0] rem;
    logic [63:0] qd;
    logic [30:0] dvs;
    side_t       side;
  } div_stage_t;

  // One restoring step: dividend bits leave the top of qd, quotient bits enter below
  function automatic div_stage_t div_step(input div_stage_t s);
    div_stage_t o;
    logic [31:0] t;
    o = s;
    t = {s.rem, s.qd[63]};
    if (t >= {1'b0, s.dvs}) begin
      o.rem = 31'(t - {1'b0, s.dvs});
      o.qd  = {s.qd[62:0], 1'b1};
    end else begin
      o.rem = t[30:0];
      o.qd  = {s.qd[62:0], 1'b0};
    end
    return o;
  endfunction

endpackage

[hdl/tphc_div.sv]
// tphc_div: pipelined unsigned 64 / 31 bit restoring divider, one quotient bit per stage.
// Carries a side payload of other results. Depends on tphc_pkg.
module tphc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [63:0]       in_dvd,
  input  logic [30:0]       in_dvs,
  input  tphc_pkg::side_t   in_side,
  output logic              out_valid,
  output logic [63:0]       out_quo,
  output tphc_pkg::side_t   out_side
);
  import tphc_pkg::*;

  div_stage_t            stg_r   [DivSteps];
  div_stage_t            stg_nxt [DivSteps];
  logic [DivSteps-1:0]   vld_r;
  div_stage_t            first;

  // Step logic for every stage
  always_comb begin
    first.rem  = '0;
    first.qd   = in_dvd;
    first.dvs  = in_dvs;
    first.side = in_side;
    stg_nxt[0] = div_step(first);
    for (int i = 1; i < DivSteps; i++) begin
      stg_nxt[i] = div_step(stg_r[i-1]);
    end
  end

  // Stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DivSteps; i++) begin
        stg_r[i] <= stg_nxt[i];
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DivSteps-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[DivSteps-1];
  assign out_quo   = stg_r[DivSteps-1].qd;
  assign out_side  = stg_r[DivSteps-1].side;

endmodule

[hdl/temp_pressure_humidity_compensation_unit.sv]
// Integer temperature / pressure / humidity compensation, 81 register stages.
// Throughput: one sample set per cycle while the output is not stalled; the 64-stage
// pressure divider sets the depth.
// A stalled output freezes the whole pipeline; in_tready is low only while it stalls.
// Reset (rst_n low, synchronous) clears all valid bits and the coefficient registers.
// Depends on tphc_pkg and tphc_div.
module temp_pressure_humidity_compensation_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // raw_temp[23:0], raw_press[47:24], raw_hum[63:48]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // temp_centi[31:0], temp_ok[32], press_q24_8[64:33],
                                  // press_ok[65], hum_q7_10[82:66], hum_ok[83], 0[87:84]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);
  import tphc_pkg::*;

  logic en;

  // ---------------- configuration registers ----------------
  logic [47:0] temp_r;
  logic [63:0] plo_r, phi_r, hum_r;
  logic [15:0] p9_r;
  logic        has_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_r <= '0;
      plo_r  <= '0;
      phi_r  <= '0;
      p9_r   <= '0;
      hum_r  <= '0;
      has_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEMP:    temp_r <= cfg_wdata[47:0];
        CFG_PLO:     plo_r  <= cfg_wdata;
        CFG_PHI:     phi_r  <= cfg_wdata;
        CFG_P9:      p9_r   <= cfg_wdata[15:0];
        CFG_HUM:     hum_r  <= cfg_wdata;
        CFG_HAS_HUM: has_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Coefficient fields
  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
  logic [7:0]         h1, h3;
  logic signed [11:0] h4, h5;
  logic signed [7:0]  h6;

  assign t1 = temp_r[15:0];
  assign t2 = temp_r[31:16];
  assign t3 = temp_r[47:32];
  assign p1 = plo_r[15:0];
  assign p2 = plo_r[31:16];
  assign p3 = plo_r[47:32];
  assign p4 = plo_r[63:48];
  assign p5 = phi_r[15:0];
  assign p6 = phi_r[31:16];
  assign p7 = phi_r[47:32];
  assign p8 = phi_r[63:48];
  assign p9 = p9_r;
  assign h1 = hum_r[7:0];
  assign h2 = hum_r[23:8];
  assign h3 = hum_r[31:24];
  assign h4 = hum_r[43:32];
  assign h5 = hum_r[55:44];
  assign h6 = hum_r[63:56];

  // ---------------- flow control ----------------
  logic [10:0] fv_r;   // valid of front stages S1..S11
  logic [5:0]  bv_r;   // valid of back stages B1..B6
  logic        div_vld;

  assign en         = !bv_r[5] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = bv_r[5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
      bv_r <= '0;
    end else if (en) begin
      fv_r <= {fv_r[9:0], in_tvalid};
      bv_r <= {bv_r[4:0], div_vld};
    end
  end

  // ---------------- front pipeline registers ----------------
  flags_t             fl_r [1:10];
  logic [19:0]        rp_r [1:8];
  logic [15:0]        rh_r [1:6];
  logic signed [31:0] tc_r [5:10];

  logic signed [18:0] s1_d_r, s1_d_nxt;
  logic signed [17:0] s1_e_r, s1_e_nxt;
  flags_t             fl_nxt;
  logic signed [31:0] s2_m1_r, s2_m1_nxt, s2_m2_r, s2_m2_nxt;
  logic signed [31:0] s3_v1_r, s3_v1_nxt, s3_m3_r, s3_m3_nxt;
  logic signed [31:0] s4_tf_r, s4_tf_nxt;
  logic signed [31:0] tc_nxt;
  logic signed [32:0] s5_pv_r, s5_pv_nxt;
  logic signed [31:0] s5_hv_r, s5_hv_nxt;
  logic signed [63:0] s6_sq_r, s6_sq_nxt, s6_q5_r, s6_q5_nxt, s6_q2_r, s6_q2_nxt;
  logic signed [31:0] s6_mh5_r, s6_mh5_nxt, s6_mh6_r, s6_mh6_nxt, s6_mh3_r, s6_mh3_nxt;
  logic signed [63:0] s7_v2a_r, s7_v2a_nxt, s7_v1a_r, s7_v1a_nxt, s7_q5_r, s7_q2_r;
  logic signed [16:0] s7_x_r, s7_x_nxt, s8_x_r;
  logic signed [31:0] s7_myz_r, s7_myz_nxt;
  logic signed [63:0] s8_v2_r, s8_v2_nxt, s8_v1_r, s8_v1_nxt;
  logic signed [31:0] s8_my_r, s8_my_nxt;
  logic signed [63:0] s9_num_r, s9_num_nxt, s9_m_r, s9_m_nxt;
  logic signed [31:0] s9_v_r, s9_v_nxt;
  logic signed [30:0] s10_dv_r, s10_dv_nxt;
  logic signed [63:0] s10_num_r, s10_num_nxt;
  logic signed [31:0] s10_zsq_r, s10_zsq_nxt, s10_v_r;
  logic [63:0]        s11_ua_r, s11_ua_nxt;
  logic [30:0]        s11_ub_r, s11_ub_nxt;
  side_t              s11_sd_r, s11_sd_nxt;

  // S1: raw words, temperature differences, enable flags
  always_comb begin
    s1_d_nxt = $signed({2'b00, in_tdata[23:7]}) - $signed({2'b00, t1, 1'b0});
    s1_e_nxt = $signed({2'b00, in_tdata[23:8]}) - $signed({2'b00, t1});
    fl_nxt.temp_ok  = in_tdata[23:0] != DIS24;
    fl_nxt.press_ok = in_tdata[47:24] != DIS24;
    fl_nxt.hum_ok   = has_r && (in_tdata[63:48] != DIS16);
  end

  // S2: first temperature products
  logic signed [34:0] m1f;
  logic signed [35:0] m2f;
  always_comb begin
    m1f = s1_d_r * t2;
    m2f = s1_e_r * s1_e_r;
    s2_m1_nxt = m1f[31:0];
    s2_m2_nxt = m2f[31:0];
  end

  // S3: square term times T3
  logic signed [31:0] a3_full;
  logic signed [19:0] a3;
  logic signed [35:0] m3f;
  always_comb begin
    a3_full   = s2_m2_r >>> 12;
    a3        = a3_full[19:0];
    m3f       = a3 * t3;
    s3_m3_nxt = m3f[31:0];
    s3_v1_nxt = s2_m1_r >>> 11;
  end

  // S4: fine temperature
  logic signed [31:0] v2t;
  always_comb begin
    v2t       = s3_m3_r >>> 14;
    s4_tf_nxt = s3_v1_r + v2t;
  end

  // S5: centidegrees and the offsets used by pressure and humidity
  logic signed [31:0] t5;
  always_comb begin
    t5        = (s4_tf_r <<< 2) + s4_tf_r + RND_128;
    tc_nxt    = t5 >>> 8;
    s5_pv_nxt = $signed({s4_tf_r[31], s4_tf_r}) - PRESS_TF_OFS;
    s5_hv_nxt = s4_tf_r - HUM_TF_OFS;
  end

  // S6: pressure square and linear terms, humidity coefficient products
  logic signed [65:0] sqf;
  logic signed [48:0] q5f, q2f;
  logic signed [43:0] mh5f;
  logic signed [39:0] mh6f;
  logic signed [40:0] mh3f;
  always_comb begin
    sqf        = s5_pv_r * s5_pv_r;
    q5f        = s5_pv_r * p5;
    q2f        = s5_pv_r * p2;
    s6_sq_nxt  = sqf[63:0];
    s6_q5_nxt  = {{15{q5f[48]}}, q5f};
    s6_q2_nxt  = {{15{q2f[48]}}, q2f};
    mh5f       = s5_hv_r * h5;
    mh6f       = s5_hv_r * h6;
    mh3f       = s5_hv_r * $signed({1'b0, h3});
    s6_mh5_nxt = mh5f[31:0];
    s6_mh6_nxt = mh6f[31:0];
    s6_mh3_nxt = mh3f[31:0];
  end

  // S7: square times P6 and P3; humidity x term and y1 * z
  logic signed [79:0] v2af, v1af;
  logic signed [31:0] xs, xsh, y1f, zf;
  logic signed [21:0] y1, z7;
  logic signed [43:0] myzf;
  always_comb begin
    v2af        = s6_sq_r * p6;
    v1af        = s6_sq_r * p3;
    s7_v2a_nxt  = v2af[63:0];
    s7_v1a_nxt  = v1af[63:0];
    xs          = $signed({2'b00, rh_r[6], 14'b0}) - $signed({h4, 20'b0}) - s6_mh5_r
                  + RND_16384;
    xsh         = xs >>> 15;
    s7_x_nxt    = xsh[16:0];
    y1f         = s6_mh6_r >>> 10;
    y1          = y1f[21:0];
    zf          = (s6_mh3_r >>> 11) + OFS_32768;
    z7          = zf[21:0];
    myzf        = y1 * z7;
    s7_myz_nxt  = myzf[31:0];
  end

  // S8: pressure v2 and offset v1 sums; humidity y times H2
  logic signed [63:0] v1sh;
  logic signed [31:0] y2f;
  logic signed [22:0] y2;
  logic signed [38:0] myf;
  always_comb begin
    s8_v2_nxt = s7_v2a_r + $signed({s7_q5_r[46:0], 17'b0})
                + $signed({{13{p4[15]}}, p4, 35'b0});
    v1sh      = s7_v1a_r >>> 8;
    s8_v1_nxt = v1sh + $signed({s7_q2_r[51:0], 12'b0}) + PRESS_V1_OFS;
    y2f       = (s7_myz_r >>> 10) + OFS_2097152;
    y2        = y2f[22:0];
    myf       = y2 * h2;
    s8_my_nxt = myf[31:0];
  end

  // S9: divisor product and numerator; humidity x * y
  logic [20:0]        pn;
  logic signed [80:0] mf;
  logic signed [31:0] y3s, y3f;
  logic signed [17:0] y3;
  logic signed [34:0] vf;
  always_comb begin
    pn         = PRESS_BASE - {1'b0, rp_r[8]};
    s9_num_nxt = $signed({12'b0, pn, 31'b0}) - s8_v2_r;
    mf         = s8_v1_r * $signed({1'b0, p1});
    s9_m_nxt   = mf[63:0];
    y3s        = s8_my_r + RND_8192;
    y3f        = y3s >>> 14;
    y3         = y3f[17:0];
    vf         = s8_x_r * y3;
    s9_v_nxt   = vf[31:0];
  end

  // S10: scaled numerator, divisor; humidity square term
  logic signed [63:0] dvf;
  logic signed [76:0] numf;
  logic signed [31:0] zzf;
  logic signed [16:0] zz;
  logic signed [33:0] zsqf;
  always_comb begin
    dvf         = s9_m_r >>> 33;
    s10_dv_nxt  = dvf[30:0];
    numf        = s9_num_r * PRESS_SCALE;
    s10_num_nxt = numf[63:0];
    zzf         = s9_v_r >>> 15;
    zz          = zzf[16:0];
    zsqf        = zz * zz;
    s10_zsq_nxt = zsqf[31:0];
  end

  // S11: divider operands; humidity finish and clamp; side payload
  logic signed [31:0] zs7f, zh, zh4, hr;
  logic signed [24:0] zs7;
  logic signed [33:0] zhf;
  logic [16:0]        hum_val;
  always_comb begin
    s11_ua_nxt = s10_num_r[63] ? 64'(-s10_num_r) : 64'(s10_num_r);
    s11_ub_nxt = s10_dv_r[30] ? 31'(-s10_dv_r) : 31'(s10_dv_r);
    zs7f       = s10_zsq_r >>> 7;
    zs7        = zs7f[24:0];
    zhf        = zs7 * $signed({1'b0, h1});
    zh         = zhf[31:0];
    zh4        = zh >>> 4;
    hr         = s10_v_r - zh4;
    if (hr < 0) begin
      hum_val = '0;
    end else if (hr > HUM_MAX) begin
      hum_val = HUM_MAX_OUT;
    end else begin
      hum_val = hr[28:12];
    end
    s11_sd_nxt.temp_centi = fl_r[10].temp_ok ? tc_r[10] : '0;
    s11_sd_nxt.temp_ok    = fl_r[10].temp_ok;
    s11_sd_nxt.press_ok   = fl_r[10].press_ok;
    s11_sd_nxt.press_zero = !fl_r[10].press_ok || (s10_dv_r == '0);
    s11_sd_nxt.neg        = s10_num_r[63] ^ s10_dv_r[30];
    s11_sd_nxt.hum        = fl_r[10].hum_ok ? hum_val : '0;
    s11_sd_nxt.hum_ok     = fl_r[10].hum_ok;
  end

  // Front register bank
  always_ff @(posedge clk) begin
    if (en) begin
      s1_d_r  <= s1_d_nxt;
      s1_e_r  <= s1_e_nxt;
      fl_r[1] <= fl_nxt;
      rp_r[1] <= in_tdata[47:28];
      rh_r[1] <= in_tdata[63:48];
      for (int i = 2; i <= 10; i++) fl_r[i] <= fl_r[i-1];
      for (int i = 2; i <= 8; i++)  rp_r[i] <= rp_r[i-1];
      for (int i = 2; i <= 6; i++)  rh_r[i] <= rh_r[i-1];
      for (int i = 6; i <= 10; i++) tc_r[i] <= tc_r[i-1];
      s2_m1_r   <= s2_m1_nxt;
      s2_m2_r   <= s2_m2_nxt;
      s3_v1_r   <= s3_v1_nxt;
      s3_m3_r   <= s3_m3_nxt;
      s4_tf_r   <= s4_tf_nxt;
      tc_r[5]   <= tc_nxt;
      s5_pv_r   <= s5_pv_nxt;
      s5_hv_r   <= s5_hv_nxt;
      s6_sq_r   <= s6_sq_nxt;
      s6_q5_r   <= s6_q5_nxt;
      s6_q2_r   <= s6_q2_nxt;
      s6_mh5_r  <= s6_mh5_nxt;
      s6_mh6_r  <= s6_mh6_nxt;
      s6_mh3_r  <= s6_mh3_nxt;
      s7_v2a_r  <= s7_v2a_nxt;
      s7_v1a_r  <= s7_v1a_nxt;
      s7_q5_r   <= s6_q5_r;
      s7_q2_r   <= s6_q2_r;
      s7_x_r    <= s7_x_nxt;
      s7_myz_r  <= s7_myz_nxt;
      s8_v2_r   <= s8_v2_nxt;
      s8_v1_r   <= s8_v1_nxt;
      s8_my_r   <= s8_my_nxt;
      s8_x_r    <= s7_x_r;
      s9_num_r  <= s9_num_nxt;
      s9_m_r    <= s9_m_nxt;
      s9_v_r    <= s9_v_nxt;
      s10_dv_r  <= s10_dv_nxt;
      s10_num_r <= s10_num_nxt;
      s10_zsq_r <= s10_zsq_nxt;
      s10_v_r   <= s9_v_r;
      s11_ua_r  <= s11_ua_nxt;
      s11_ub_r  <= s11_ub_nxt;
      s11_sd_r  <= s11_sd_nxt;
    end
  end

  // ---------------- pressure divider ----------------
  logic [63:0] div_quo;
  side_t       div_sd;

  tphc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fv_r[10]),
    .in_dvd    (s11_ua_r),
    .in_dvs    (s11_ub_r),
    .in_side   (s11_sd_r),
    .out_valid (div_vld),
    .out_quo   (div_quo),
    .out_side  (div_sd)
  );

  // ---------------- back pipeline ----------------
  side_t              sd_r [1:5];
  logic signed [63:0] b1_p_r, b1_p_nxt;
  logic signed [63:0] b2_p_r, b2_ps_r, b2_ps_nxt, b2_m9_r, b2_m9_nxt, b2_m8_r, b2_m8_nxt;
  logic [63:0]        b3_pp0_r, b3_pp0_nxt;
  logic [31:0]        b3_pp1_r, b3_pp1_nxt, b3_pp2_r, b3_pp2_nxt;
  logic signed [63:0] b3_p_r, b3_m8_r;
  logic signed [63:0] b4_mm_r, b4_mm_nxt, b4_p_r, b4_m8_r;
  logic signed [63:0] b5_pf_r, b5_pf_nxt;
  logic [87:0]        out_r, out_nxt;

  // B1: signed quotient
  always_comb begin
    b1_p_nxt = div_sd.neg ? -$signed(div_quo) : $signed(div_quo);
  end

  // B2: P9 and P8 products
  logic signed [79:0] m9f, m8f;
  always_comb begin
    b2_ps_nxt = b1_p_r >>> 13;
    m9f       = b2_ps_nxt * p9;
    m8f       = b1_p_r * p8;
    b2_m9_nxt = m9f[63:0];
    b2_m8_nxt = m8f[63:0];
  end

  // B3: 64 x 64 wrap product split into 32-bit partials
  logic [63:0] ppa, ppb, ppc;
  always_comb begin
    ppa        = b2_m9_r[31:0] * b2_ps_r[31:0];
    ppb        = b2_m9_r[31:0] * b2_ps_r[63:32];
    ppc        = b2_m9_r[63:32] * b2_ps_r[31:0];
    b3_pp0_nxt = ppa;
    b3_pp1_nxt = ppb[31:0];
    b3_pp2_nxt = ppc[31:0];
  end

  // B4: partial product sum
  logic [31:0] pp_hi;
  always_comb begin
    pp_hi     = b3_pp1_r + b3_pp2_r;
    b4_mm_nxt = $signed(b3_pp0_r + {pp_hi, 32'b0});
  end

  // B5: final pressure sum
  logic signed [63:0] pv1b, pv2b, psum, psh;
  always_comb begin
    pv1b      = b4_mm_r >>> 25;
    pv2b      = b4_m8_r >>> 19;
    psum      = b4_p_r + pv1b + pv2b;
    psh       = psum >>> 8;
    b5_pf_nxt = psh + $signed({{44{p7[15]}}, p7, 4'b0});
  end

  // B6: saturate and pack the result
  logic [31:0] pres;
  always_comb begin
    if (sd_r[5].press_zero || b5_pf_r[63]) begin
      pres = '0;
    end else if (b5_pf_r[62:32] != '0) begin
      pres = '1;
    end else begin
      pres = b5_pf_r[31:0];
    end
    out_nxt = {4'b0, sd_r[5].hum_ok, sd_r[5].hum, sd_r[5].press_ok, pres,
               sd_r[5].temp_ok, sd_r[5].temp_centi};
  end

  // Back register bank
  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[1] <= div_sd;
      for (int i = 2; i <= 5; i++) sd_r[i] <= sd_r[i-1];
      b1_p_r   <= b1_p_nxt;
      b2_p_r   <= b1_p_r;
      b2_ps_r  <= b2_ps_nxt;
      b2_m9_r  <= b2_m9_nxt;
      b2_m8_r  <= b2_m8_nxt;
      b3_pp0_r <= b3_pp0_nxt;
      b3_pp1_r <= b3_pp1_nxt;
      b3_pp2_r <= b3_pp2_nxt;
      b3_p_r   <= b2_p_r;
      b3_m8_r  <= b2_m8_r;
      b4_mm_r  <= b4_mm_nxt;
      b4_p_r   <= b3_p_r;
      b4_m8_r  <= b3_m8_r;
      b5_pf_r  <= b5_pf_nxt;
      out_r    <= out_nxt;
    end
  end

  assign out_tdata = out_r;

endmodule

[hdl/tphc_checker.sv]
// tphc_checker: port-level checks of the compensation unit, bound to the top level.
// Depends only on the top level's ports.
module tphc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Nothing comes out right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Input side never refuses while the output is empty
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input refused with empty output");

  // Disabled temperature gives zero
  a_temp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[32] |-> out_tdata[31:0] == 32'd0)
    else $error("disabled temperature not zero");

  // Humidity within range and zero when not valid
  a_hum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[82:66] <= 17'd102400
                   && (out_tdata[83] || out_tdata[82:66] == 17'd0))
    else $error("humidity out of range");

endmodule

bind temp_pressure_humidity_compensation_unit tphc_checker u_tphc_checker (.*);
